@@ hdl/rcpf_pkg.sv @@
// Shared types, constants and helper functions for the robot command packet framer.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package rcpf_pkg;

  // Fixed-point format of the incoming numbers
  localparam int VAL_FRAC_BITS = 16;
  localparam int VAL_BITS      = 32;
  localparam int POW_BITS      = 24;   // 10^7 fits in 24 bits
  localparam int PROD_BITS     = VAL_BITS + POW_BITS;
  localparam int SCALED_BITS   = 21;   // low bits of the scaled number that are sent
  localparam int SHIFT_BITS    = 3;
  localparam int NUM_VALUES    = 5;

  // Packet layout
  localparam int PKT_MAX_LEN   = 18;
  localparam int IDX_BITS      = $clog2(PKT_MAX_LEN);
  localparam int HDR_BYTES     = 2;
  localparam int NUM_BYTES     = 3;
  localparam logic [IDX_BITS-1:0] LAST_IDX_SHORT = IDX_BITS'(11);
  localparam logic [IDX_BITS-1:0] LAST_IDX_LONG  = IDX_BITS'(17);
  localparam logic [IDX_BITS-1:0] LAST_IDX_REQ   = IDX_BITS'(2);

  localparam logic [7:0] DIGIT_BASE = 8'h30;
  localparam logic [3:0] ID_MAX     = 4'd9;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_SHORT = 2'd0,
    OP_LONG  = 2'd1,
    OP_REQ   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]                 op;
    logic [7:0]                 command_type;
    logic [3:0]                 unit_id;
    logic signed [VAL_BITS-1:0] value_1;
    logic signed [VAL_BITS-1:0] value_2;
    logic signed [VAL_BITS-1:0] value_3;
    logic signed [VAL_BITS-1:0] value_4;
    logic signed [VAL_BITS-1:0] value_5;
    logic [SHIFT_BITS-1:0]      decimal_shift;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_item_t;

  // One framed packet, checksum not yet filled in
  typedef struct packed {
    logic [IDX_BITS-1:0]              last_idx;
    logic [PKT_MAX_LEN-1:0][7:0]      bytes;
  } pkt_t;

  function automatic logic [POW_BITS-1:0] pow_ten(input logic [SHIFT_BITS-1:0] shift);
    logic [POW_BITS-1:0] p;
    begin
      unique case (shift)
        3'd0:    p = POW_BITS'(1);
        3'd1:    p = POW_BITS'(10);
        3'd2:    p = POW_BITS'(100);
        3'd3:    p = POW_BITS'(1000);
        3'd4:    p = POW_BITS'(10000);
        3'd5:    p = POW_BITS'(100000);
        3'd6:    p = POW_BITS'(1000000);
        default: p = POW_BITS'(10000000);
      endcase
      return p;
    end
  endfunction

endpackage

@@ hdl/robot_command_packet_framer.sv @@
// Top level of the robot command packet framer: front end, packet queue, byte serializer.
// Depends on rcpf_pkg, rcpf_front, rcpf_queue and rcpf_back.
//
//   channel   ports                          payload
//   input     in_valid / in_ready            in_data  (rcpf_pkg::in_item_t), one command
//   output    out_valid / out_ready          out_data (rcpf_pkg::out_item_t), one byte
//
// A command passes the front-end capture and number-scaling stages (one multiplier
// per number), then waits in a two-entry queue.
// The serializer sends one byte per cycle unless out_ready stalls it; a command
// is 12, 18 or 3 bytes (short, long, position); packets go back to back with no gap.
// Unused op codes are dropped at the input and produce no bytes.
// rst_n is synchronous and active low; it empties all stages and the queue.
// A stalled output holds the serializer; the front end keeps filling the queue
// and drops in_ready once the queue and both front stages are full.
module robot_command_packet_framer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rcpf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rcpf_pkg::out_item_t out_data
);

  logic           push_valid;
  logic           push_ready;
  rcpf_pkg::pkt_t push_data;
  logic           pop_valid;
  logic           pop_ready;
  rcpf_pkg::pkt_t pop_data;

  rcpf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rcpf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rcpf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ hdl/rcpf_front.sv @@
// Front end: accepts command items, drops unused op codes, scales the numbers
// and builds the packet bytes. Depends on rcpf_pkg.
module rcpf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rcpf_pkg::in_item_t in_data,
  output logic               push_valid,
  input  logic               push_ready,
  output rcpf_pkg::pkt_t     push_data
);

  // Stage 1: captured item
  logic               s1_valid_r;
  rcpf_pkg::in_item_t s1_item_r;

  // Stage 2: scaled numbers and header bytes
  logic                                    s2_valid_r;
  logic [rcpf_pkg::NUM_VALUES-1:0]         s2_neg_r;
  logic [rcpf_pkg::SCALED_BITS-1:0]        s2_scaled_r [rcpf_pkg::NUM_VALUES];
  logic [7:0]                              s2_type_r;
  logic [7:0]                              s2_digit_r;
  logic [rcpf_pkg::SHIFT_BITS-1:0]         s2_shift_r;
  logic [rcpf_pkg::IDX_BITS-1:0]           s2_last_idx_r;

  logic s1_free;
  logic s2_free;

  logic signed [rcpf_pkg::VAL_BITS-1:0]  lane_val   [rcpf_pkg::NUM_VALUES];
  logic [rcpf_pkg::VAL_BITS-1:0]         lane_mag   [rcpf_pkg::NUM_VALUES];
  logic [rcpf_pkg::PROD_BITS-1:0]        lane_prod  [rcpf_pkg::NUM_VALUES];
  logic [rcpf_pkg::NUM_VALUES-1:0]       lane_neg;
  logic [rcpf_pkg::POW_BITS-1:0]         scale;
  logic [3:0]                            id_sat;
  logic [7:0]                            digit;
  logic [rcpf_pkg::IDX_BITS-1:0]         last_idx;

  assign s2_free  = !s2_valid_r || push_ready;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_ready = s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      // drop items with the unused op code here
      s1_valid_r <= in_valid && (in_data.op != rcpf_pkg::OP_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_item_r <= in_data;
    end
  end

  // One multiplier per number lane
  always_comb begin
    lane_val[0] = s1_item_r.value_1;
    lane_val[1] = s1_item_r.value_2;
    lane_val[2] = s1_item_r.value_3;
    lane_val[3] = s1_item_r.value_4;
    lane_val[4] = s1_item_r.value_5;
    scale = rcpf_pkg::pow_ten(s1_item_r.decimal_shift);
    for (int i = 0; i < rcpf_pkg::NUM_VALUES; i++) begin
      lane_neg[i]  = lane_val[i][rcpf_pkg::VAL_BITS-1];
      lane_mag[i]  = lane_neg[i] ? (~lane_val[i] + rcpf_pkg::VAL_BITS'(1)) : lane_val[i];
      lane_prod[i] = rcpf_pkg::PROD_BITS'(lane_mag[i]) * rcpf_pkg::PROD_BITS'(scale);
    end
  end

  always_comb begin
    id_sat = (s1_item_r.unit_id > rcpf_pkg::ID_MAX) ? rcpf_pkg::ID_MAX : s1_item_r.unit_id;
    digit  = rcpf_pkg::DIGIT_BASE + {4'd0, id_sat};
    unique case (s1_item_r.op)
      rcpf_pkg::OP_LONG:  last_idx = rcpf_pkg::LAST_IDX_LONG;
      rcpf_pkg::OP_REQ:   last_idx = rcpf_pkg::LAST_IDX_REQ;
      default:            last_idx = rcpf_pkg::LAST_IDX_SHORT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_neg_r      <= lane_neg;
      s2_type_r     <= s1_item_r.command_type;
      s2_digit_r    <= digit;
      s2_shift_r    <= s1_item_r.decimal_shift;
      s2_last_idx_r <= last_idx;
      for (int i = 0; i < rcpf_pkg::NUM_VALUES; i++) begin
        s2_scaled_r[i] <= lane_prod[i][rcpf_pkg::VAL_FRAC_BITS +: rcpf_pkg::SCALED_BITS];
      end
    end
  end

  // Restore the sign and pack each number into three bytes
  always_comb begin
    logic [rcpf_pkg::SCALED_BITS-1:0] s;
    logic [23:0]                      w;
    s = '0;
    w = '0;
    push_data.last_idx = s2_last_idx_r;
    push_data.bytes    = '0;
    push_data.bytes[0] = s2_type_r;
    push_data.bytes[1] = s2_digit_r;
    for (int i = 0; i < rcpf_pkg::NUM_VALUES; i++) begin
      s = s2_neg_r[i] ? (~s2_scaled_r[i] + rcpf_pkg::SCALED_BITS'(1)) : s2_scaled_r[i];
      w = {s, s2_shift_r};
      push_data.bytes[rcpf_pkg::HDR_BYTES + rcpf_pkg::NUM_BYTES*i]     = w[23:16];
      push_data.bytes[rcpf_pkg::HDR_BYTES + rcpf_pkg::NUM_BYTES*i + 1] = w[15:8];
      push_data.bytes[rcpf_pkg::HDR_BYTES + rcpf_pkg::NUM_BYTES*i + 2] = w[7:0];
    end
  end

  assign push_valid = s2_valid_r;

endmodule

@@ hdl/rcpf_queue.sv @@
// Short packet queue between the front end and the byte serializer.
// Depends on rcpf_pkg.
module rcpf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  rcpf_pkg::pkt_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rcpf_pkg::pkt_t pop_data
);

  rcpf_pkg::pkt_t                   slot_r [rcpf_pkg::QUEUE_DEPTH];
  logic [rcpf_pkg::QPTR_BITS-1:0]   wr_ptr_r;
  logic [rcpf_pkg::QPTR_BITS-1:0]   rd_ptr_r;
  logic [rcpf_pkg::QCNT_BITS-1:0]   count_r;
  logic                             do_push;
  logic                             do_pop;

  assign push_ready = (count_r != rcpf_pkg::QCNT_BITS'(rcpf_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [rcpf_pkg::QPTR_BITS-1:0] ptr_inc(
    input logic [rcpf_pkg::QPTR_BITS-1:0] p
  );
    begin
      return (p == rcpf_pkg::QPTR_BITS'(rcpf_pkg::QUEUE_DEPTH - 1)) ? '0
             : p + rcpf_pkg::QPTR_BITS'(1);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + rcpf_pkg::QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - rcpf_pkg::QCNT_BITS'(1);
      end
    end
  end

endmodule

@@ hdl/rcpf_back.sv @@
// Back end: sends a queued packet one byte per cycle when out_ready allows,
// and appends the checksum. Depends on rcpf_pkg.
module rcpf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  rcpf_pkg::pkt_t      pop_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rcpf_pkg::out_item_t out_data
);

  logic                          active_r;
  rcpf_pkg::pkt_t                pkt_r;
  logic [rcpf_pkg::IDX_BITS-1:0] idx_r;
  logic [7:0]                    sum_r;
  logic                          out_valid_r;
  rcpf_pkg::out_item_t           out_data_r;

  logic       emit;
  logic       is_last;
  logic [7:0] cur_byte;
  logic       load;

  assign emit      = active_r && (!out_valid_r || out_ready);
  assign is_last   = (idx_r == pkt_r.last_idx);
  // checksum is 0xFF minus the running sum
  assign cur_byte  = is_last ? ~sum_r : pkt_r.bytes[idx_r];
  assign pop_ready = !active_r || (emit && is_last);
  assign load      = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        active_r <= 1'b1;
      end else if (emit && is_last) begin
        active_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.out_byte  <= cur_byte;
      out_data_r.last_byte <= is_last;
    end
    if (load) begin
      // start the next packet right behind the checksum byte
      pkt_r <= pop_data;
      idx_r <= '0;
      sum_r <= '0;
    end else if (emit) begin
      idx_r <= idx_r + rcpf_pkg::IDX_BITS'(1);
      sum_r <= sum_r + cur_byte;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
